>>> rtl/pkcm_pkg.sv
// ----------------------------------------------------------------------------
// pkcm_pkg
// shared types, constants and helper functions of the keyword coverage matcher
// ----------------------------------------------------------------------------
`default_nettype none

package pkcm_pkg;

    localparam int KEYWORD_MAX_DEF = 32;
    localparam int CHAR_W          = 8;
    localparam int LEN_W           = 6;
    localparam int BEST_W          = 6;
    localparam int THR_W           = 17;
    localparam int FRAC_W          = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int CHARS_PER_REG   = 8;
    localparam int GRP_W           = 8;
    localparam int GRP_CNT_W       = 4;
    localparam int OUT_TDATA_W     = 8;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(65536);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KW_LOW      = 3'd0,
        CFG_KW_MID_LOW  = 3'd1,
        CFG_KW_MID_HIGH = 3'd2,
        CFG_KW_HIGH     = 3'd3,
        CFG_KW_LENGTH   = 3'd4,
        CFG_THRESHOLD   = 3'd5
    } t_cfg_index;

    // status handed from one cell to its neighbor and to the top level
    typedef struct packed {
        logic in_use;   // position lies inside the effective keyword
        logic live;     // stored prefix-match bit
        logic hit;      // prefix ending here with the current byte
        logic reached;  // prefix of this length seen in the text so far
        logic sig;      // keyword char here is not whitespace
        logic tail;     // final position of the effective keyword
    } t_cell_out;

    // per-result flags riding along the scoring pipeline
    typedef struct packed {
        logic              whole;
        logic              empty;
        logic              ge_one;
        logic [FRAC_W-1:0] thr;
    } t_score_flags;

    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [GRP_CNT_W-1:0] pop_grp(input logic [GRP_W-1:0] v);
        logic [GRP_CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < GRP_W; i++) begin
            n = n + GRP_CNT_W'(v[i]);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

>>> rtl/partial_keyword_coverage_match_unit.sv
// ----------------------------------------------------------------------------
// partial_keyword_coverage_match_unit
// case-insensitive keyword search with prefix coverage scoring
// ----------------------------------------------------------------------------
// throughput: one text byte per cycle; the cell row updates all prefix bits
//   of a byte together; input stalls only while all four scoring
//   stages hold results and the output item is not taken
// pipeline: four register stages (capture, group count, total, decision); the
//   result item is held in the decision stage until it is taken
// reset: synchronous active low; clears the cell row, the scoring pipeline
//   and the config registers (threshold resets to 1.0)
// ----------------------------------------------------------------------------
`default_nettype none

module partial_keyword_coverage_match_unit
    import pkcm_pkg::*;
#(
    parameter int KEYWORD_MAX = KEYWORD_MAX_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // text in
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [CHAR_W-1:0]      i_s_axis_tdata,  // [7:0] text_char
    input  wire logic                   i_s_axis_tlast,  // last_char
    // result out
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,  // [0] is_match,
                                                         // [1] fully_contained,
                                                         // [7:2] best_significant
    // config write
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // config registers, only the chars the cell row can use are kept
    logic [KEYWORD_MAX*CHAR_W-1:0] r_kw;
    logic [LEN_W-1:0]              r_kw_len;
    logic [THR_W-1:0]              r_thr;

    logic            r_seen_whole;
    logic            n_seen_whole;

    logic            w_accept;
    logic            w_cfg_we;
    logic [CHAR_W-1:0] w_char;
    t_cell_out       w_cell [KEYWORD_MAX];
    t_cell_out       w_prev [KEYWORD_MAX];
    logic [KEYWORD_MAX-1:0] w_next_in_use;
    logic [KEYWORD_MAX-1:0] w_hit_tail;
    logic [KEYWORD_MAX-1:0] w_best_vec;
    logic [KEYWORD_MAX-1:0] w_sig_vec;
    t_score_flags    w_flags;
    logic            w_score_ready;
    logic            w_match;
    logic            w_whole;
    logic [BEST_W-1:0] w_best;

    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = w_score_ready;
    assign o_cfg_ready     = 1'b1;
    assign w_cfg_we        = i_cfg_valid && o_cfg_ready;
    assign w_char          = fold_case(i_s_axis_tdata);

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kw     <= '0;
            r_kw_len <= '0;
            r_thr    <= THR_RESET;
        end else if (w_cfg_we) begin
            // keyword bytes: register i holds chars 8i .. 8i+7
            for (int b = 0; b < KEYWORD_MAX; b++) begin
                if (i_cfg_index == CFG_IDX_W'(b / CHARS_PER_REG)) begin
                    r_kw[b*CHAR_W +: CHAR_W] <=
                        i_cfg_data[(b % CHARS_PER_REG)*CHAR_W +: CHAR_W];
                end
            end
            unique case (i_cfg_index)
                CFG_KW_LENGTH: r_kw_len <= i_cfg_data[LEN_W-1:0];
                CFG_THRESHOLD: r_thr    <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- cell row
    // the boundary cell sees a virtual neighbor that is always in use and
    // always live, so a new prefix can start at position 0 on every byte
    always_comb begin
        for (int k = 0; k < KEYWORD_MAX; k++) begin
            if (k == 0) begin
                w_prev[k] = '{in_use: 1'b1, live: 1'b1, hit: 1'b0,
                              reached: 1'b0, sig: 1'b0, tail: 1'b0};
            end else begin
                w_prev[k] = w_cell[k-1];
            end
            if (k == KEYWORD_MAX - 1) begin
                w_next_in_use[k] = 1'b0;
            end else begin
                w_next_in_use[k] = w_cell[k+1].in_use;
            end
            w_hit_tail[k] = w_cell[k].hit && w_cell[k].tail;
            // reached is a thermometer, masked by in_use it stops at the
            // effective length, so its significant chars give best_significant
            w_best_vec[k] = w_cell[k].reached && w_cell[k].sig;
            w_sig_vec[k]  = w_cell[k].sig;
        end
    end

    for (genvar k = 0; k < KEYWORD_MAX; k++) begin : g_cell
        logic w_len_ok;
        // keyword length saturates at the row length by construction
        assign w_len_ok = (r_kw_len > LEN_W'(k));

        pkcm_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_accept      (w_accept),
            .i_last        (i_s_axis_tlast),
            .i_char        (w_char),
            .i_kw_char     (r_kw[k*CHAR_W +: CHAR_W]),
            .i_len_ok      (w_len_ok),
            .i_prev        (w_prev[k]),
            .i_next_in_use (w_next_in_use[k]),
            .o_cell        (w_cell[k])
        );
    end

    // whole keyword seen: the last keyword cell matched on some byte
    assign n_seen_whole = r_seen_whole || (|w_hit_tail);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_whole <= 1'b0;
        end else if (w_accept) begin
            r_seen_whole <= i_s_axis_tlast ? 1'b0 : n_seen_whole;
        end
    end

    // ---------------------------------------------------------------- scoring
    always_comb begin
        w_flags.empty  = !w_cell[0].in_use;
        w_flags.whole  = n_seen_whole && w_cell[0].in_use;
        w_flags.ge_one = r_thr[THR_W-1];
        w_flags.thr    = r_thr[FRAC_W-1:0];
    end

    pkcm_score #(
        .KEYWORD_MAX (KEYWORD_MAX)
    ) u_score (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_accept && i_s_axis_tlast),
        .o_ready    (w_score_ready),
        .i_best_vec (w_best_vec),
        .i_sig_vec  (w_sig_vec),
        .i_flags    (w_flags),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_match    (w_match),
        .o_whole    (w_whole),
        .o_best     (w_best)
    );

    assign o_m_axis_tdata = {w_best, w_whole, w_match};

endmodule

`default_nettype wire

>>> rtl/pkcm_cell.sv
// ----------------------------------------------------------------------------
// pkcm_cell
// one keyword position: char compare, live prefix bit and reached flag
// ----------------------------------------------------------------------------
`default_nettype none

module pkcm_cell
    import pkcm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic              i_last,
    input  wire logic [CHAR_W-1:0] i_char,        // folded text byte
    input  wire logic [CHAR_W-1:0] i_kw_char,
    input  wire logic              i_len_ok,
    input  wire t_cell_out         i_prev,
    input  wire logic              i_next_in_use,
    output t_cell_out              o_cell
);

    logic r_live;
    logic r_reached;
    logic n_live;
    logic w_in_use;

    // keyword stops at the first zero char
    assign w_in_use = i_prev.in_use && i_len_ok && (i_kw_char != '0);
    assign n_live   = i_prev.live && w_in_use && (fold_case(i_kw_char) == i_char);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live    <= 1'b0;
            r_reached <= 1'b0;
        end else if (i_accept) begin
            if (i_last) begin
                r_live    <= 1'b0;
                r_reached <= 1'b0;
            end else begin
                r_live    <= n_live;
                r_reached <= r_reached || n_live;
            end
        end
    end

    always_comb begin
        o_cell.in_use  = w_in_use;
        o_cell.live    = r_live;
        o_cell.hit     = n_live;
        o_cell.reached = (r_reached || n_live) && w_in_use;
        o_cell.sig     = w_in_use && !is_blank(i_kw_char);
        o_cell.tail    = w_in_use && !i_next_in_use;
    end

endmodule

`default_nettype wire

>>> rtl/pkcm_score.sv
// ----------------------------------------------------------------------------
// pkcm_score
// counts significant chars and applies the threshold rule, four register stages
// ----------------------------------------------------------------------------
`default_nettype none

module pkcm_score
    import pkcm_pkg::*;
#(
    parameter int KEYWORD_MAX = KEYWORD_MAX_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [KEYWORD_MAX-1:0] i_best_vec,
    input  wire logic [KEYWORD_MAX-1:0] i_sig_vec,
    input  wire t_score_flags           i_flags,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic                        o_match,
    output logic                        o_whole,
    output logic [BEST_W-1:0]           o_best
);

    localparam int NGRP  = (KEYWORD_MAX + GRP_W - 1) / GRP_W;
    localparam int PAD_W = NGRP * GRP_W;
    localparam int CNT_W = $clog2(KEYWORD_MAX + 1);
    localparam int PRD_W = CNT_W + FRAC_W;

    // stage a: captured vectors
    logic                 r_va;
    logic [PAD_W-1:0]     r_best_vec;
    logic [PAD_W-1:0]     r_sig_vec;
    t_score_flags         r_fa;
    // stage b: group counts
    logic                 r_vb;
    logic [GRP_CNT_W-1:0] r_best_grp [NGRP];
    logic [GRP_CNT_W-1:0] r_sig_grp  [NGRP];
    t_score_flags         r_fb;
    // stage c: totals
    logic                 r_vc;
    logic [CNT_W-1:0]     r_best_c;
    logic [CNT_W-1:0]     r_sig_c;
    t_score_flags         r_fc;
    // output register
    logic                 r_ov;
    logic                 r_match;
    logic                 r_whole;
    logic [CNT_W-1:0]     r_best;

    logic en_a, en_b, en_c, en_o;
    logic [CNT_W-1:0] n_best_c;
    logic [CNT_W-1:0] n_sig_c;
    logic [PRD_W-1:0] w_lhs;
    logic [PRD_W-1:0] w_rhs;
    logic             n_match;

    assign en_o    = !r_ov || i_ready;
    assign en_c    = !r_vc || en_o;
    assign en_b    = !r_vb || en_c;
    assign en_a    = !r_va || en_b;
    assign o_ready = en_a;

    always_comb begin
        n_best_c = '0;
        n_sig_c  = '0;
        for (int g = 0; g < NGRP; g++) begin
            n_best_c = n_best_c + CNT_W'(r_best_grp[g]);
            n_sig_c  = n_sig_c + CNT_W'(r_sig_grp[g]);
        end
    end

    // best * 1.0 >= threshold * sig, all in 16-bit fraction units
    assign w_lhs = {r_best_c, {FRAC_W{1'b0}}};
    assign w_rhs = PRD_W'(r_fc.thr) * PRD_W'(r_sig_c);

    always_comb begin
        if (r_fc.empty) begin
            n_match = 1'b0;
        end else if (r_fc.ge_one) begin
            n_match = r_fc.whole;
        end else if (r_sig_c == '0) begin
            n_match = (r_fc.thr == '0);
        end else begin
            n_match = (w_lhs >= w_rhs);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (en_a) r_va <= i_valid;
            if (en_b) r_vb <= r_va;
            if (en_c) r_vc <= r_vb;
            if (en_o) r_ov <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_best_vec <= PAD_W'(i_best_vec);
            r_sig_vec  <= PAD_W'(i_sig_vec);
            r_fa       <= i_flags;
        end
        if (en_b) begin
            for (int g = 0; g < NGRP; g++) begin
                r_best_grp[g] <= pop_grp(r_best_vec[g*GRP_W +: GRP_W]);
                r_sig_grp[g]  <= pop_grp(r_sig_vec[g*GRP_W +: GRP_W]);
            end
            r_fb <= r_fa;
        end
        if (en_c) begin
            r_best_c <= n_best_c;
            r_sig_c  <= n_sig_c;
            r_fc     <= r_fb;
        end
        if (en_o) begin
            r_match <= n_match;
            r_whole <= r_fc.whole;
            r_best  <= r_best_c;
        end
    end

    assign o_valid = r_ov;
    assign o_match = r_match;
    assign o_whole = r_whole;
    assign o_best  = BEST_W'(r_best);

endmodule

`default_nettype wire

>>> dv/partial_keyword_coverage_match_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// partial_keyword_coverage_match_unit_test
// self-checking bench for the case-insensitive keyword coverage matcher:
// streams text bytes under random idling, predicts every per-text verdict
// with a shift-and model of its own and compares each result item by field
// ----------------------------------------------------------------------------

module partial_keyword_coverage_match_unit_test;
    import pkcm_pkg::*;

    localparam int          RESET_CYCLES    = 7;
    localparam int          DRAIN_CYCLES    = 16;
    localparam int          CYCLE_LIMIT     = 200000;
    localparam int          KW_MAX          = 32;
    localparam int unsigned ONE_FIXED       = 65536;  // threshold of 1.0
    localparam int          MODES           = 3;
    localparam int          PHASES_PER_MODE = 4;
    localparam int          ITEMS_PER_PHASE = 80;
    localparam int          REPORT_MAX      = 10;

    // indexes past the register list, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_item_t;

    typedef struct packed {
        logic             is_match;
        logic             whole;
        logic [BEST_W-1:0] best;
    } verdict_t;

    // clock, reset and block inputs, all known from time zero
    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic [CHAR_W-1:0]     i_s_axis_tdata  = '0;
    logic                  i_s_axis_tlast  = 1'b0;
    logic                  i_m_axis_tready = 1'b0;
    logic                  i_cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                  o_cfg_ready;

    // mirror of the config registers, updated on each accepted write
    logic [8*KW_MAX-1:0]   kw_bytes  = '0;
    logic [LEN_W-1:0]      kw_len    = '0;
    logic [THR_W-1:0]      kw_thr    = THR_RESET;

    // matcher state as the block should hold it
    logic [KW_MAX-1:0]     prefix_live    = '0;
    int unsigned           prefix_longest = 0;
    logic                  kw_seen        = 1'b0;

    text_item_t            text_q[$];     // bytes waiting for the driver
    verdict_t              verdict_q[$];  // verdicts owed by the block
    int unsigned           items_queued   = 0;
    int unsigned           items_taken    = 0;
    int unsigned           mismatches     = 0;
    int unsigned           cycle_count    = 0;
    int unsigned           send_idle_pct  = 0;
    int unsigned           recv_idle_pct  = 0;

    partial_keyword_coverage_match_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // [7:0] text_char
        .i_s_axis_tlast  (i_s_axis_tlast),   // last_char
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [0] is_match, [1] fully_contained,
                                             // [7:2] best_significant
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // only A-Z fold, everything above 0x7f compares as is
    function automatic logic [CHAR_W-1:0] lower_ascii(input logic [CHAR_W-1:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // length in use: capped at the maximum and cut at the first zero char
    function automatic int unsigned kw_used_len();
        int unsigned n;
        n = (kw_len > KW_MAX) ? KW_MAX : kw_len;
        for (int unsigned i = 0; i < n; i++) begin
            if (kw_bytes[i*8 +: 8] == 8'h00) begin
                return i;
            end
        end
        return n;
    endfunction

    function automatic int unsigned significant_chars(input int unsigned n);
        int unsigned cnt;
        cnt = 0;
        for (int unsigned i = 0; i < n; i++) begin
            if (!is_space(kw_bytes[i*8 +: 8])) begin
                cnt++;
            end
        end
        return cnt;
    endfunction

    // advance the prefix vector by one byte; returns 1 when a verdict is due
    function automatic logic predict_byte(input logic [CHAR_W-1:0] ch, input logic last,
                                          output verdict_t v);
        int unsigned len, lp, best, sig;
        logic [KW_MAX-1:0] eq, nxt;
        logic [CHAR_W-1:0] c;
        v   = '0;
        c   = lower_ascii(ch);
        len = kw_used_len();
        eq  = '0;
        for (int unsigned k = 0; k < len; k++) begin
            if (lower_ascii(kw_bytes[k*8 +: 8]) == c) begin
                eq[k] = 1'b1;
            end
        end
        nxt = ({prefix_live[KW_MAX-2:0], 1'b0} | 1) & eq;
        prefix_live = nxt;
        for (int unsigned k = 0; k < len; k++) begin
            if (nxt[k] && k + 1 > prefix_longest) begin
                prefix_longest = k + 1;
            end
        end
        if (len > 0 && nxt[len-1]) begin
            kw_seen = 1'b1;
        end
        if (!last) begin
            return 1'b0;
        end
        if (len > 0) begin
            lp   = (prefix_longest > len) ? len : prefix_longest;
            best = significant_chars(lp);
            sig  = significant_chars(len);
            v.whole = kw_seen;
            v.best  = best[BEST_W-1:0];
            if (kw_thr >= ONE_FIXED) begin
                v.is_match = kw_seen;
            end else if (sig == 0) begin
                // all-blank keyword: coverage is zero
                v.is_match = (kw_thr == 0);
            end else begin
                v.is_match = (longint'(best) * ONE_FIXED >= longint'(kw_thr) * sig);
            end
        end
        prefix_live    = '0;
        prefix_longest = 0;
        kw_seen        = 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // text driver: one item per handshake, random gaps per idle setting
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : text_driver
        text_item_t nxt_item;
        verdict_t   v;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                if (predict_byte(i_s_axis_tdata, i_s_axis_tlast, v)) begin
                    verdict_q.push_back(v);
                end
                items_taken++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt_item = text_q.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= nxt_item.ch;
                    i_s_axis_tlast  <= nxt_item.last;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: random back-pressure, compare against oldest verdict
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        verdict_t got, want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.is_match = o_m_axis_tdata[0];
                got.whole    = o_m_axis_tdata[1];
                got.best     = o_m_axis_tdata[7:2];
                if (verdict_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("[%0t] unexpected result item: match=%0b whole=%0b best=%0d",
                                 $realtime, got.is_match, got.whole, got.best);
                    end
                end else begin
                    want = verdict_q.pop_front();
                    if (got.is_match !== want.is_match || got.whole !== want.whole ||
                        got.best !== want.best) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX) begin
                            $display(
                                "[%0t] exp/got match %0b/%0b whole %0b/%0b best %0d/%0d",
                                $realtime, want.is_match, got.is_match,
                                want.whole, got.whole, want.best, got.best);
                        end
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // raise the write channel and hold it until accepted; caller lowers valid
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (idx)
            CFG_KW_LOW:      kw_bytes[63:0]    = val;
            CFG_KW_MID_LOW:  kw_bytes[127:64]  = val;
            CFG_KW_MID_HIGH: kw_bytes[191:128] = val;
            CFG_KW_HIGH:     kw_bytes[255:192] = val;
            CFG_KW_LENGTH:   kw_len            = val[LEN_W-1:0];
            CFG_THRESHOLD:   kw_thr            = val[THR_W-1:0];
            default: ;       // spare index, ignored by the block
        endcase
    endtask

    task automatic load_keyword(input logic [8*KW_MAX-1:0] chars, input int unsigned len,
                                input int unsigned limit);
        cfg_write(CFG_KW_LOW,      chars[63:0]);
        cfg_write(CFG_KW_MID_LOW,  chars[127:64]);
        cfg_write(CFG_KW_MID_HIGH, chars[191:128]);
        cfg_write(CFG_KW_HIGH,     chars[255:192]);
        cfg_write(CFG_KW_LENGTH,   64'(len));
        cfg_write(CFG_THRESHOLD,   64'(limit));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [8*KW_MAX-1:0] kw_from(input string s);
        logic [8*KW_MAX-1:0] r;
        r = '0;
        for (int i = 0; i < s.len() && i < KW_MAX; i++) begin
            r[i*8 +: 8] = s[i];
        end
        return r;
    endfunction

    task automatic push_byte(input logic [CHAR_W-1:0] c, input logic last);
        text_item_t it;
        it.ch   = c;
        it.last = last;
        text_q.push_back(it);
        items_queued++;
    endtask

    task automatic push_text(input string s, input logic ends);
        for (int i = 0; i < s.len(); i++) begin
            push_byte(s[i], ends && i == s.len() - 1);
        end
    endtask

    // sender holds off until every byte is taken and every verdict is back
    task automatic wait_quiet();
        do begin
            @(posedge i_clk);
        end while (items_taken != items_queued || verdict_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // letters, blanks and anything from 1 to 255
    function automatic logic [CHAR_W-1:0] rand_char();
        logic [CHAR_W-1:0] c;
        case ($urandom_range(3))
            0: c = ($urandom_range(1) ? 8'h41 : 8'h61) + 8'($urandom_range(25));
            1: c = ($urandom_range(5) == 5) ? 8'h20 : 8'h09 + 8'($urandom_range(4));
            default: c = 8'($urandom_range(1, 255));
        endcase
        return c;
    endfunction

    // one text: keyword fragments with flipped case and stray bytes, plus noise
    task automatic gen_text(output int unsigned n);
        logic [CHAR_W-1:0] body[$];
        logic [CHAR_W-1:0] c;
        int unsigned len, segs, start, span;
        len  = kw_used_len();
        segs = $urandom_range(1, 3);
        for (int unsigned s = 0; s < segs; s++) begin
            if (len > 0 && $urandom_range(99) < 65) begin
                start = ($urandom_range(99) < 80) ? 0 : $urandom_range(len - 1);
                span  = ($urandom_range(99) < 40) ? len - start
                                                  : $urandom_range(1, len - start);
                for (int unsigned k = start; k < start + span; k++) begin
                    c = kw_bytes[k*8 +: 8];
                    if ($urandom_range(99) < 6) begin
                        c = rand_char();
                    end else if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
                                 && $urandom_range(1)) begin
                        c ^= 8'h20;
                    end
                    body.push_back(c);
                end
            end else begin
                repeat ($urandom_range(1, 6)) body.push_back(rand_char());
            end
        end
        for (int k = 0; k < body.size(); k++) begin
            push_byte(body[k], k == body.size() - 1);
        end
        n = body.size();
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [8*KW_MAX-1:0] chars;
        int unsigned         len, sent, n;
        int                  limit, m;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty keyword straight out of reset: all fields zero
        push_text("Ab", 1'b1);
        wait_quiet();

        // plain containment across case, then the byte extremes
        load_keyword(kw_from("Key"), 3, ONE_FIXED);
        push_text("xKEY", 1'b1);
        push_byte(8'h01, 1'b0);
        push_byte(8'hFF, 1'b1);
        wait_quiet();

        // coverage exactly on the threshold, blank not counted
        load_keyword(kw_from("a b"), 3, ONE_FIXED / 2);
        push_text("A", 1'b1);
        wait_quiet();

        // all-blank keyword: zero threshold matches, any other does not
        load_keyword(kw_from(" \t"), 2, 0);
        push_text(" ", 1'b1);
        wait_quiet();
        cfg_write(CFG_THRESHOLD, 64'd1);
        i_cfg_valid <= 1'b0;
        push_text(" \t", 1'b1);
        wait_quiet();

        // zero char inside the keyword ends it early
        chars = kw_from("ab");
        chars[31:24] = 8'h63;
        chars[39:32] = 8'h64;
        load_keyword(chars, 5, ONE_FIXED);
        push_text("AB", 1'b1);
        wait_quiet();

        // spare register indexes, then oversized length and threshold above one
        cfg_write(CFG_SPARE_LO, '1);
        cfg_write(CFG_SPARE_HI, '1);
        load_keyword(kw_from("Partial Keyword Coverage Matcher"), 63, 131071);
        push_text("pAr", 1'b1);
        wait_quiet();

        // bytes above 0x7f compare exactly, no folding
        chars = '0;
        chars[7:0]  = 8'hC1;
        chars[15:8] = 8'hE1;
        load_keyword(chars, 2, ONE_FIXED);
        push_byte(8'hC1, 1'b0);
        push_byte(8'hE1, 1'b1);
        wait_quiet();

        // length shortened in the middle of a text
        load_keyword(kw_from("abcd"), 4, ONE_FIXED);
        push_text("xab", 1'b0);
        wait_quiet();
        cfg_write(CFG_KW_LENGTH, 64'd2);
        i_cfg_valid <= 1'b0;
        push_text("b", 1'b1);
        wait_quiet();

        // random part: three idling modes, several keyword settings in each
        for (int mode = 0; mode < MODES; mode++) begin
            case (mode)
                0: begin send_idle_pct = 11; recv_idle_pct = 60; end
                1: begin send_idle_pct = 60; recv_idle_pct = 11; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int ph = 0; ph < PHASES_PER_MODE; ph++) begin
                for (int i = 0; i < KW_MAX; i++) begin
                    chars[i*8 +: 8] = rand_char();
                end
                if (ph == 0) begin
                    len = 1;
                end else if (ph == 1) begin
                    len = KW_MAX;
                end else if (ph == 3 && mode == 2) begin
                    len = 0;
                end else begin
                    len = $urandom_range(1, KW_MAX);
                end
                // now and then a zero char cuts the keyword short
                if (len > 1 && $urandom_range(7) == 0) begin
                    chars[$urandom_range(1, len - 1)*8 +: 8] = 8'h00;
                end
                case ($urandom_range(5))
                    0: limit = 0;
                    1: limit = ONE_FIXED;
                    2, 3: limit = $urandom_range(ONE_FIXED);
                    default: begin
                        // near a ratio j/m so the compare sits on its edge
                        m = $urandom_range(1, KW_MAX);
                        limit = ($urandom_range(m) * ONE_FIXED) / m + $urandom_range(2) - 1;
                        if (limit < 0) limit = 0;
                        if (limit > ONE_FIXED) limit = ONE_FIXED;
                    end
                endcase
                load_keyword(chars, len, limit);
                sent = 0;
                while (sent < ITEMS_PER_PHASE) begin
                    gen_text(n);
                    sent += n;
                end
                wait_quiet();
            end
        end

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/pkcm_pkg.sv
rtl/pkcm_cell.sv
rtl/pkcm_score.sv
rtl/partial_keyword_coverage_match_unit.sv
dv/partial_keyword_coverage_match_unit_test.sv
